// File: hdl/modexp_pkg.sv
// Shared constants and types for the modular exponentiation unit.
package modexp_pkg;
	localparam int WORD_BITS = 64;
	localparam int CNT_BITS = $clog2(WORD_BITS);
	localparam int REG_MODULUS = 0;
	localparam int REG_EXPONENT = 1;
	localparam int CFG_IDX_BITS = 1;
	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WORD_BITS:0] wide_t;

	// One cell's control: double the accumulator, optionally add the addend.
	typedef struct packed {
		logic add_en;
	} cell_ctrl_t;
endpackage

// File: hdl/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit.
// Each request word is raised to the configured exponent modulo the configured modulus by
// left-to-right square-and-multiply. Every modular product runs through a row of two
// shift-and-add cells. A request first has its base reduced modulo the modulus, one bit a
// cycle, and then takes a squaring per exponent bit, plus a multiplication by the base when
// the bit is set. One request is worked at a time. The result register holds a finished
// result while the next request is accepted and worked; that next result waits until the
// first is taken. A zero modulus gives bad_modulus and a zero result in the cycle after the
// request is accepted, which needs the result register to be free.
module modular_exponentiation_unit import modexp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  word_t                   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  word_t                   base_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output word_t                   power_result,
	output logic                    bad_modulus
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_SQ   = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [2:0] ST_WAIT = 3'd5;

	word_t modulus_q, exponent_q;
	logic [2:0] state_q;
	word_t acc_q, base_q, ex_q, red_q, rsh_q;
	logic [CNT_BITS-1:0] bit_q;
	logic sq_q;
	logic mul_start, mul_done;
	word_t mul_a, mul_b, product;
	wide_t red2;
	logic out_free;
	logic out_load;

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE) && ((modulus_q != '0) || out_free);
	assign out_load = ((state_q == ST_IDLE) && in_valid && in_ready && (modulus_q == '0)) ||
		((state_q == ST_OUT) && (bit_q == '0) && out_free);
	assign mul_a = sq_q ? acc_q : base_q;
	assign mul_b = acc_q;
	assign red2 = {red_q, rsh_q[WORD_BITS-1]};

	modexp_mulchain u_mul (.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a),
		.b(mul_b), .modulus(modulus_q), .done(mul_done), .product(product));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= '0;
			exponent_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IDX_BITS'(REG_MODULUS)) modulus_q <= cfg_data;
			else if (cfg_index == CFG_IDX_BITS'(REG_EXPONENT)) exponent_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			mul_start <= 1'b0;
			sq_q <= 1'b0;
			bit_q <= '0;
			power_result <= '0;
			bad_modulus <= 1'b0;
			acc_q <= '0;
			base_q <= '0;
			ex_q <= '0;
			red_q <= '0;
			rsh_q <= '0;
		end else begin
			mul_start <= 1'b0;
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (modulus_q == '0) begin
							power_result <= '0;
							bad_modulus <= 1'b1;
						end else begin
							red_q <= '0;
							rsh_q <= base_value;
							ex_q <= exponent_q;
							acc_q <= (modulus_q == word_t'(1)) ? '0 : word_t'(1);
							bit_q <= CNT_BITS'(WORD_BITS - 1);
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: begin
					// Restoring reduction of the base, one bit per cycle.
					red_q <= (red2 >= {1'b0, modulus_q}) ?
						word_t'(red2 - {1'b0, modulus_q}) : red2[WORD_BITS-1:0];
					rsh_q <= {rsh_q[WORD_BITS-2:0], 1'b0};
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= ST_WAIT;
						bit_q <= CNT_BITS'(WORD_BITS - 1);
					end
				end
				ST_WAIT: begin
					base_q <= red_q;
					sq_q <= 1'b1;
					mul_start <= 1'b1;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (mul_done) begin
						acc_q <= product;
						if (ex_q[WORD_BITS-1]) begin
							sq_q <= 1'b0;
							mul_start <= 1'b1;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						acc_q <= product;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (bit_q == '0) begin
						// A finished result waits here while the previous one is still held.
						if (out_free) begin
							power_result <= acc_q;
							bad_modulus <= 1'b0;
							state_q <= ST_IDLE;
						end
					end else begin
						ex_q <= {ex_q[WORD_BITS-2:0], 1'b0};
						bit_q <= bit_q - 1'b1;
						sq_q <= 1'b1;
						mul_start <= 1'b1;
						state_q <= ST_SQ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/modexp_cell.sv
// One shift-and-add modular step: acc = 2*acc (+ a) mod m, for acc, a < m.
module modexp_cell import modexp_pkg::*; (
	input  word_t      acc_in,
	input  word_t      addend,
	input  word_t      modulus,
	input  cell_ctrl_t ctrl,
	output word_t      acc_out
);
	wide_t dbl;
	wide_t dbl_red;
	wide_t sum;

	always_comb begin
		dbl = {acc_in, 1'b0};
		dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
		sum = dbl_red + {1'b0, addend};
		if (ctrl.add_en && sum >= {1'b0, modulus}) begin
			sum = sum - {1'b0, modulus};
		end
		acc_out = ctrl.add_en ? sum[WORD_BITS-1:0] : dbl_red[WORD_BITS-1:0];
	end
endmodule

// File: hdl/modexp_mulchain.sv
// Modular multiplier built from a row of two cells, handling two multiplier bits per cycle.
module modexp_mulchain import modexp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t a,
	input  word_t b,
	input  word_t modulus,
	output logic  done,
	output word_t product
);
	localparam int STEPS = WORD_BITS / 2;
	localparam int SC_BITS = $clog2(STEPS + 1);

	word_t acc_q;
	word_t b_q;
	logic [SC_BITS-1:0] cnt_q;
	logic busy_q;
	word_t mid;
	word_t nxt;
	cell_ctrl_t c0, c1;

	assign c0.add_en = b_q[WORD_BITS-1];
	assign c1.add_en = b_q[WORD_BITS-2];

	modexp_cell u_c0 (.acc_in(acc_q), .addend(a), .modulus(modulus), .ctrl(c0), .acc_out(mid));
	modexp_cell u_c1 (.acc_in(mid), .addend(a), .modulus(modulus), .ctrl(c1), .acc_out(nxt));

	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= SC_BITS'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SC_BITS'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			b_q <= b;
		end else if (busy_q) begin
			acc_q <= nxt;
			b_q <= {b_q[WORD_BITS-3:0], 2'b00};
		end
	end
endmodule
